[src/phase_angle_rectifier_timing_top_macros.svh]
// ----------------------------------------------------------------------------
// Phase-angle rectifier timing: assertion macros
// Shared concurrent assertion forms for the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef PHASE_ANGLE_RECTIFIER_TIMING_TOP_MACROS_SVH
`define PHASE_ANGLE_RECTIFIER_TIMING_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PAR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("phase rectifier timing: property violated");

// Next-cycle implication, disabled during reset.
`define PAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("phase rectifier timing: property violated");

`endif

[src/par_pkg.sv]
// ----------------------------------------------------------------------------
// Phase-angle rectifier timing: package
// Register indexes, widths, constants and the per-tick control record.
// ----------------------------------------------------------------------------
package par_pkg;

  localparam int unsigned GLITCH_TICKS = 100;

  localparam logic [23:0] TIMEOUT_RESET = 24'd1000000;

  // One half turn in 1/16 degree; 2880 = 64 * 45.
  localparam logic [11:0] HALF_TURN = 12'd2880;

  // ceil(2^31 / 45): exact quotient for 25-bit dividends.
  localparam logic [25:0] RECIP_HALF = 26'd47721859;

  // ceil(2^24 / 45): exact quotient for 18-bit dividends.
  localparam logic [18:0] RECIP_REM = 19'd372828;

  typedef logic [2:0]  cfg_idx_t;
  typedef logic [31:0] cfg_data_t;
  typedef logic [31:0] tick_t;
  typedef logic [11:0] angle_t;
  typedef logic [23:0] timeout_t;

  localparam cfg_idx_t REG_SYSTEM_ENABLE = 3'd0;
  localparam cfg_idx_t REG_SPEED_ENABLE  = 3'd1;
  localparam cfg_idx_t REG_SPEED_START   = 3'd2;
  localparam cfg_idx_t REG_SPEED_STOP    = 3'd3;
  localparam cfg_idx_t REG_ANGLE_ON      = 3'd4;
  localparam cfg_idx_t REG_ANGLE_OFF     = 3'd5;
  localparam cfg_idx_t REG_TIMEOUT       = 3'd6;

  // What one tick leaves for the back end of the pipeline.
  typedef struct packed {
    tick_t       tick;    // tick count of this item
    logic        sw;      // switching enabled at the start of the tick
    logic        cr;      // control reset during evaluation
    logic        upd;     // rebase the compare points on this tick
    logic        act;     // phase active after the tick
    logic        en;      // switching enabled after the tick
    tick_t       period;  // full period after the tick
    logic [30:0] half;    // half of the accepted interval
  } step_ctl_t;

endpackage

[src/par_if.sv]
// ----------------------------------------------------------------------------
// Phase-angle rectifier timing: channel interfaces
// Tick input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface par_in_if;
  logic valid;
  logic ready;
  logic edge_req;

  modport source (output valid, output edge_req, input ready);
  modport sink   (input valid, input edge_req, output ready);
endinterface

interface par_out_if;
  logic           valid;
  logic           ready;
  logic           gate_drive;
  logic           phase_active;
  logic           outputs_enabled;
  par_pkg::tick_t full_period;

  modport source (output valid, output gate_drive, output phase_active,
                  output outputs_enabled, output full_period, input ready);
  modport sink   (input valid, input gate_drive, input phase_active,
                  input outputs_enabled, input full_period, output ready);
endinterface

[src/par_front.sv]
// ----------------------------------------------------------------------------
// Phase-angle rectifier timing: front end
// Configuration registers, tick counter, edge timing, timeout and speed
// hysteresis; produces the control record of each accepted tick.
// ----------------------------------------------------------------------------
`include "phase_angle_rectifier_timing_top_macros.svh"

module par_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  par_pkg::cfg_idx_t    cfg_index,
  input  par_pkg::cfg_data_t   cfg_data,
  input  logic                 step,
  input  logic                 edge_req,
  output par_pkg::step_ctl_t   ctl,
  output par_pkg::angle_t      angle_on,
  output par_pkg::angle_t      angle_off
);
  import par_pkg::*;

  logic     system_enable;
  logic     speed_enable;
  tick_t    speed_start;
  tick_t    speed_stop;
  timeout_t timeout_ticks;

  tick_t    tick_count;
  tick_t    last_edge;
  tick_t    period;
  logic     armed;
  timeout_t timeout_left;
  logic     active;
  logic     sw;

  tick_t    last_edge_next;
  tick_t    period_next;
  logic     armed_next;
  timeout_t timeout_left_next;
  logic     active_next;
  logic     sw_next;
  logic     cr;
  logic     upd;
  tick_t    delta;
  logic     accept_edge;
  logic [30:0] half_eval;

  assign delta       = tick_count - last_edge;
  assign accept_edge = edge_req && armed && (delta > tick_t'(GLITCH_TICKS));

  always_comb begin
    timeout_left_next = (timeout_left != '0) ? timeout_left - 24'd1 : '0;
    armed_next        = armed;
    last_edge_next    = last_edge;
    period_next       = period;
    active_next       = active;
    sw_next           = sw;
    cr                = 1'b0;
    upd               = 1'b0;

    if (edge_req) begin
      timeout_left_next = timeout_ticks;
      if (!armed) begin
        armed_next = 1'b1;
      end
    end
    if (accept_edge) begin
      last_edge_next = tick_count;
      period_next    = delta;
      upd            = active && sw;
    end

    half_eval = period_next[31:1];
    if (system_enable) begin
      if (timeout_left_next == '0) begin
        active_next = 1'b0;
      end else begin
        if (speed_enable) begin
          if (speed_stop < {1'b0, half_eval}) begin
            active_next = 1'b0;
          end else if (speed_start > {1'b0, half_eval}) begin
            active_next = 1'b1;
          end
        end else begin
          active_next = 1'b1;
        end
        // Switching follows the active decision through a control reset.
        if (active_next != sw) begin
          cr                = 1'b1;
          sw_next           = active_next;
          armed_next        = 1'b0;
          active_next       = 1'b0;
          timeout_left_next = '0;
        end
      end
    end
  end

  always_comb begin
    ctl.tick   = tick_count;
    ctl.sw     = sw;
    ctl.cr     = cr;
    ctl.upd    = upd;
    ctl.act    = active_next;
    ctl.en     = sw_next;
    ctl.period = period_next;
    ctl.half   = delta[31:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      system_enable <= 1'b0;
      speed_enable  <= 1'b0;
      speed_start   <= '0;
      speed_stop    <= '0;
      angle_on      <= '0;
      angle_off     <= '0;
      timeout_ticks <= TIMEOUT_RESET;
      tick_count    <= '0;
      last_edge     <= '0;
      period        <= '0;
      armed         <= 1'b0;
      timeout_left  <= '0;
      active        <= 1'b0;
      sw            <= 1'b0;
    end else begin
      if (step) begin
        tick_count   <= tick_count + 32'd1;
        last_edge    <= last_edge_next;
        period       <= period_next;
        armed        <= armed_next;
        timeout_left <= timeout_left_next;
        active       <= active_next;
        sw           <= sw_next;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SYSTEM_ENABLE: begin
            system_enable <= cfg_data[0];
            armed         <= 1'b0;
            active        <= 1'b0;
            timeout_left  <= '0;
            sw            <= cfg_data[0];
          end
          REG_SPEED_ENABLE: speed_enable  <= cfg_data[0];
          REG_SPEED_START:  speed_start   <= cfg_data;
          REG_SPEED_STOP:   speed_stop    <= cfg_data;
          REG_ANGLE_ON:     angle_on      <= cfg_data[11:0];
          REG_ANGLE_OFF:    angle_off     <= cfg_data[11:0];
          REG_TIMEOUT:      timeout_ticks <= cfg_data[23:0];
          default: ;
        endcase
      end
    end
  end

  `PAR_ASSERT_NEXT(a_period_above_glitch, clk, rst, step && accept_edge, period > tick_t'(GLITCH_TICKS))

endmodule

[src/par_scale.sv]
// ----------------------------------------------------------------------------
// Phase-angle rectifier timing: angle scaling pipeline
// Four stages computing floor(angle * half / 2880) for both angles, and the
// tick of the second half period.
// ----------------------------------------------------------------------------
module par_scale (
  input  logic            clk,
  input  logic [5:2]      ld,
  input  par_pkg::tick_t  tick_in,
  input  logic [30:0]     half_in,
  input  par_pkg::angle_t angle_on,
  input  par_pkg::angle_t angle_off,
  output par_pkg::tick_t  on_ofs,
  output par_pkg::tick_t  off_ofs,
  output par_pkg::tick_t  tick_half
);
  import par_pkg::*;

  // half = 2880 * qh + rh, so angle * half / 2880 = angle * qh + angle * rh / 2880.
  logic [50:0] qh_prod;
  logic [19:0] qh2;
  logic [30:0] h2;
  tick_t       t2;

  logic [30:0] rem_full;
  logic [19:0] qh3;
  logic [11:0] rh3;
  tick_t       th3;

  tick_t       pa_on4;
  tick_t       pa_off4;
  logic [23:0] pr_on4;
  logic [23:0] pr_off4;
  tick_t       th4;

  logic [36:0] rq_on;
  logic [36:0] rq_off;

  assign qh_prod  = {26'd0, half_in[30:6]} * {25'd0, RECIP_HALF};
  assign rem_full = h2 - ({11'd0, qh2} * 31'(HALF_TURN));
  assign rq_on    = {19'd0, pr_on4[23:6]} * {18'd0, RECIP_REM};
  assign rq_off   = {19'd0, pr_off4[23:6]} * {18'd0, RECIP_REM};

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      qh2 <= qh_prod[50:31];
      h2  <= half_in;
      t2  <= tick_in;
    end
    if (ld[3]) begin
      qh3 <= qh2;
      rh3 <= rem_full[11:0];
      th3 <= t2 + {1'b0, h2};
    end
    if (ld[4]) begin
      pa_on4  <= {20'd0, angle_on} * {12'd0, qh3};
      pa_off4 <= {20'd0, angle_off} * {12'd0, qh3};
      pr_on4  <= {12'd0, angle_on} * {12'd0, rh3};
      pr_off4 <= {12'd0, angle_off} * {12'd0, rh3};
      th4     <= th3;
    end
    if (ld[5]) begin
      on_ofs    <= pa_on4 + {20'd0, rq_on[35:24]};
      off_ofs   <= pa_off4 + {20'd0, rq_off[35:24]};
      tick_half <= th4;
    end
  end

endmodule

[src/phase_angle_rectifier_timing_top.sv]
// ----------------------------------------------------------------------------
// Phase-angle rectifier timing: top level
// Times rectifier gate switching from sensor edges, one timer tick per item.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                          handshake
//   tick     in   edge_req                                         valid/ready
//   result   out  gate_drive, phase_active, outputs_enabled,       valid/ready
//                 full_period[31:0]
//   cfg      in   cfg_index[2:0], cfg_data[31:0]                   cfg_write
//
// One tick is taken every clock cycle while the output side keeps up; a
// result passes the front, scaling and output registers. The depth is set
// by the angle scaling chain (two reciprocal multiplies and two angle
// multiplies) that must land the new compare points before the next tick
// reaches the compare stage. rst is synchronous and active high; it clears
// the tick counter, all timing state, the compare points and the pipeline.
// Every stage has its own valid bit, so ticks keep entering while a result
// waits, until the pipeline fills.
`include "phase_angle_rectifier_timing_top_macros.svh"

module phase_angle_rectifier_timing_top (
  input  logic               clk,
  input  logic               rst,
  par_in_if.sink             tick,
  par_out_if.source          result,
  input  logic               cfg_write,
  input  par_pkg::cfg_idx_t  cfg_index,
  input  par_pkg::cfg_data_t cfg_data
);
  import par_pkg::*;

  localparam int STAGES = 6;

  logic [STAGES:1] v;
  logic [STAGES:1] ld;
  logic            accept;
  logic            xfer;

  step_ctl_t front_ctl;
  step_ctl_t pipe [1:STAGES-1];

  angle_t angle_on;
  angle_t angle_off;
  tick_t  on_ofs;
  tick_t  off_ofs;
  tick_t  tick_half;

  // Gate state and the four compare points live at the compare stage.
  logic  gate_level;
  logic  gate_next;
  tick_t points [4];
  tick_t points_new [4];

  logic  out_gate;
  logic  out_active;
  logic  out_enabled;
  tick_t out_period;

  // Load a stage when it is empty or its item moves on.
  always_comb begin
    ld[STAGES] = !v[STAGES] || result.ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  assign tick.ready = ld[1];
  assign accept     = tick.valid && ld[1];
  assign xfer       = ld[STAGES] && v[STAGES-1];

  par_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (accept),
    .edge_req  (tick.edge_req),
    .ctl       (front_ctl),
    .angle_on  (angle_on),
    .angle_off (angle_off)
  );

  par_scale u_scale (
    .clk       (clk),
    .ld        (ld[5:2]),
    .tick_in   (pipe[1].tick),
    .half_in   (pipe[1].half),
    .angle_on  (angle_on),
    .angle_off (angle_off),
    .on_ofs    (on_ofs),
    .off_ofs   (off_ofs),
    .tick_half (tick_half)
  );

  // Advance valid bits; a bubble moves like an item.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[1]) begin
        v[1] <= accept;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (ld[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Carry each tick's control record alongside the scaling chain.
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      pipe[1] <= front_ctl;
    end
    for (int k = 2; k <= STAGES - 1; k++) begin
      if (ld[k]) begin
        pipe[k] <= pipe[k-1];
      end
    end
  end

  // Compare first, with the points in place before this tick; a control
  // reset of the same tick then drops the gate.
  always_comb begin
    gate_next = gate_level;
    if (pipe[STAGES-1].sw) begin
      for (int k = 0; k < 4; k++) begin
        if (points[k] == pipe[STAGES-1].tick) begin
          gate_next = ~k[0];
        end
      end
    end
    if (pipe[STAGES-1].cr) begin
      gate_next = 1'b0;
    end
  end

  // Rebase the points on the edge tick: on/off, then a half period later.
  always_comb begin
    points_new[0] = pipe[STAGES-1].tick + on_ofs;
    points_new[1] = pipe[STAGES-1].tick + off_ofs;
    points_new[2] = tick_half + on_ofs;
    points_new[3] = tick_half + off_ofs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_level <= 1'b0;
      points     <= '{default: '0};
    end else begin
      if (xfer) begin
        gate_level <= gate_next;
        if (pipe[STAGES-1].upd) begin
          points <= points_new;
        end
      end
      // A write of the enable register is a control reset: drop the gate.
      if (cfg_write && (cfg_index == REG_SYSTEM_ENABLE)) begin
        gate_level <= 1'b0;
      end
    end
  end

  // Output register: hold the result until it is taken.
  always_ff @(posedge clk) begin
    if (ld[STAGES]) begin
      out_gate    <= gate_next;
      out_active  <= pipe[STAGES-1].act;
      out_enabled <= pipe[STAGES-1].en;
      out_period  <= pipe[STAGES-1].period;
    end
  end

  assign result.valid           = v[STAGES];
  assign result.gate_drive      = out_gate;
  assign result.phase_active    = out_active;
  assign result.outputs_enabled = out_enabled;
  assign result.full_period     = out_period;

  `PAR_ASSERT_IMPL(a_active_needs_switching, clk, rst, result.valid && result.phase_active, result.outputs_enabled)
  `PAR_ASSERT_NEXT(a_gate_moves_on_transfer, clk, rst, !xfer && !cfg_write, $stable(gate_level))
  `PAR_ASSERT_IMPL(a_reset_tick_inactive, clk, rst, v[1] && pipe[1].cr, !pipe[1].act)

endmodule
